FILE: design/link_activity_load_meter_assert.svh
// Assertion macros for the link activity load meter.
// Used by lalm_back, which checks its own control logic; no other dependency.
`ifndef LINK_ACTIVITY_LOAD_METER_ASSERT_SVH
`define LINK_ACTIVITY_LOAD_METER_ASSERT_SVH
`ifndef SYNTHESIS
`define LALM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define LALM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LALM_ASSERT_IMP(lbl, ante, cons, msg)
`define LALM_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

FILE: design/lalm_pkg.sv
// Shared types and constants for the link activity load meter.
// No dependencies.
package lalm_pkg;
	localparam int TOTAL_W      = 31;
	localparam int RATE_W       = 5;
	localparam int TICK_W       = 6;
	localparam int HEIGHT_W     = 4;
	localparam int INDEX_W      = 4;
	localparam int HEIGHT_MAX   = 15;
	localparam int SCALE_MIN    = 16;
	localparam int RATE_RESET   = 10;
	localparam int DATA_W       = 32;
	localparam int ADDR_W       = 3;
	localparam int QUEUE_DEPTH  = 2;
	localparam int DEF_WINDOW_DEPTH = 120;
	localparam int DEF_COLUMN_COUNT = 16;
	localparam int DEF_BAR_STEPS    = 15;

	localparam logic REG_UPDATE_RATE = 1'b0;

	typedef struct packed {
		logic               link_present;
		logic               stats_valid;
		logic [TOTAL_W-1:0] rx_total;
		logic [TOTAL_W-1:0] tx_total;
	} tick_t;

	typedef struct packed {
		logic                rx_light;
		logic                tx_light;
		logic                connected_light;
		logic                column_valid;
		logic [INDEX_W-1:0]  column_index;
		logic [HEIGHT_W-1:0] rx_height;
		logic [HEIGHT_W-1:0] tx_height;
		logic                last;
	} meter_t;

	// classified tick handed from front to back
	typedef struct packed {
		logic               rl;
		logic               tl;
		logic               cl;
		logic               sample;
		logic [TOTAL_W-1:0] rxd;
		logic [TOTAL_W-1:0] txd;
	} cmd_t;
endpackage

FILE: design/lalm_front.sv
// Front end: accepts ticks, drives light decisions and computes sample deltas.
// Depends on lalm_pkg.
module lalm_front import lalm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [RATE_W-1:0] rate,
	input  logic              accept,
	input  tick_t             tick,
	output cmd_t              cmd
);
	logic [TICK_W-1:0]  tick_count_q;
	logic [TOTAL_W-1:0] prev_rx_q, prev_tx_q, base_rx_q, base_tx_q;
	logic               link_was_up_q;

	logic [TICK_W-1:0]  tc_n;
	logic               samp;
	logic [TOTAL_W-1:0] rx, tx, brx, btx;

	always_comb begin
		tc_n = tick_count_q + 1'b1;
		samp = tc_n > {rate, 1'b0};
		rx   = tick.stats_valid ? tick.rx_total : '0;
		tx   = tick.stats_valid ? tick.tx_total : '0;
		brx  = link_was_up_q ? base_rx_q : rx;
		btx  = link_was_up_q ? base_tx_q : tx;
		cmd.cl     = tick.link_present;
		cmd.rl     = tick.link_present && tick.stats_valid && (rx > prev_rx_q);
		cmd.tl     = tick.link_present && tick.stats_valid && (tx > prev_tx_q);
		cmd.sample = samp;
		cmd.rxd    = (tick.link_present && rx > brx) ? rx - brx : '0;
		cmd.txd    = (tick.link_present && tx > btx) ? tx - btx : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q  <= '0;
			prev_rx_q     <= '0;
			prev_tx_q     <= '0;
			base_rx_q     <= '0;
			base_tx_q     <= '0;
			link_was_up_q <= 1'b0;
		end else if (accept) begin
			tick_count_q <= samp ? '0 : tc_n;
			if (tick.link_present) begin
				prev_rx_q <= rx;
				prev_tx_q <= tx;
				if (samp) begin
					base_rx_q     <= rx;
					base_tx_q     <= tx;
					link_was_up_q <= 1'b1;
				end
			end else begin
				link_was_up_q <= 1'b0;
			end
		end
	end
endmodule

FILE: design/lalm_queue.sv
// Short queue of classified ticks between front and back end.
// Depends on lalm_pkg.
module lalm_queue import lalm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wdata,
	input  logic pop,
	output cmd_t rdata,
	output logic full,
	output logic empty
);
	localparam int PW = $clog2(QUEUE_DEPTH);

	cmd_t            mem_q [QUEUE_DEPTH];
	logic [PW-1:0]   wp_q, rp_q;
	logic [PW:0]     cnt_q;

	assign full  = cnt_q == (PW+1)'(QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == PW'(QUEUE_DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (pop)  rp_q <= (rp_q == PW'(QUEUE_DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end
endmodule

FILE: design/lalm_back.sv
// Back end: peak window, column histories, max scan, height scaling, output register.
// Depends on lalm_pkg and the assertion macro header.
`include "link_activity_load_meter_assert.svh"
module lalm_back import lalm_pkg::*; #(
	parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
	parameter int COLUMN_COUNT = DEF_COLUMN_COUNT,
	parameter int BAR_STEPS    = DEF_BAR_STEPS
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   empty,
	input  cmd_t   cmd,
	output logic   pop,
	output logic   out_valid,
	input  logic   out_stall,
	output meter_t out_data
);
	localparam int WAW = $clog2(WINDOW_DEPTH);
	localparam int CW  = $clog2(COLUMN_COUNT);
	localparam int BW  = $clog2(BAR_STEPS + 1);
	localparam int NW  = TOTAL_W + BW + 5;

	localparam logic [2:0] ST_IDLE = 3'd0, ST_ENTER = 3'd1, ST_SCAN = 3'd2,
		ST_SCAN_END = 3'd3, ST_MUL = 3'd4, ST_DIV = 3'd5, ST_EMIT = 3'd6;

	logic [2:0]         state_q;
	cmd_t               cmd_q;
	logic [TOTAL_W-1:0] win_mem [WINDOW_DEPTH];
	logic [WAW-1:0]     wpos_q, scan_q;
	logic               full_q;
	logic [TOTAL_W-1:0] rd_s1;
	logic               rd_ok_s1;
	logic [TOTAL_W-1:0] mx_q;
	logic [TOTAL_W-1:0] rxcol_q [COLUMN_COUNT];
	logic [TOTAL_W-1:0] txcol_q [COLUMN_COUNT];
	logic [CW-1:0]      col_q;
	logic [NW-1:0]      nrx_q, ntx_q;
	logic [2:0]         step_q;
	logic [HEIGHT_W-1:0] qrx_q, qtx_q;
	logic               satrx_q, sattx_q, small_q;
	logic               out_vld_q;
	meter_t             out_q;

	logic               out_free;
	logic               out_load;
	logic [WAW-1:0]     wpos_n;
	logic [TOTAL_W-1:0] peak;
	logic               entry_ok;
	logic [NW-1:0]      dv;
	logic [HEIGHT_W-1:0] hrx, htx;

	assign out_free  = !out_vld_q || !out_stall;
	assign out_valid = out_vld_q;
	assign out_data  = out_q;
	assign pop       = (state_q == ST_IDLE) && !empty && (cmd.sample || out_free);
	assign out_load  = (pop && !cmd.sample) || (state_q == ST_EMIT && out_free);

	always_comb begin
		wpos_n   = (wpos_q == WAW'(WINDOW_DEPTH-1)) ? '0 : wpos_q + 1'b1;
		peak     = (cmd_q.txd > cmd_q.rxd) ? cmd_q.txd : cmd_q.rxd;
		// an entry never written since reset counts as zero
		entry_ok = full_q || (scan_q != '0 && scan_q <= wpos_q);
		dv       = NW'(mx_q) << step_q;
		if (small_q) begin
			hrx = (rxcol_q[0] > TOTAL_W'(HEIGHT_MAX)) ? HEIGHT_W'(HEIGHT_MAX)
				: rxcol_q[0][HEIGHT_W-1:0];
			htx = (txcol_q[0] > TOTAL_W'(HEIGHT_MAX)) ? HEIGHT_W'(HEIGHT_MAX)
				: txcol_q[0][HEIGHT_W-1:0];
		end else begin
			hrx = satrx_q ? HEIGHT_W'(HEIGHT_MAX) : qrx_q;
			htx = sattx_q ? HEIGHT_W'(HEIGHT_MAX) : qtx_q;
		end
	end

	// window memory: one write in ENTER, one registered read per scan cycle
	always_ff @(posedge clk) begin
		if (state_q == ST_ENTER) win_mem[wpos_n] <= peak;
		rd_s1 <= win_mem[scan_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cmd_q     <= '0;
			wpos_q    <= '0;
			scan_q    <= '0;
			full_q    <= 1'b0;
			rd_ok_s1  <= 1'b0;
			mx_q      <= '0;
			col_q     <= '0;
			nrx_q     <= '0;
			ntx_q     <= '0;
			step_q    <= '0;
			qrx_q     <= '0;
			qtx_q     <= '0;
			satrx_q   <= 1'b0;
			sattx_q   <= 1'b0;
			small_q   <= 1'b0;
			out_vld_q <= 1'b0;
			out_q     <= '0;
			for (int i = 0; i < COLUMN_COUNT; i++) begin
				rxcol_q[i] <= '0;
				txcol_q[i] <= '0;
			end
		end else begin
			if (out_vld_q && !out_stall && !out_load) out_vld_q <= 1'b0;
			rd_ok_s1 <= (state_q == ST_SCAN) && entry_ok;
			if (rd_ok_s1 && rd_s1 > mx_q) mx_q <= rd_s1;
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						cmd_q <= cmd;
						if (cmd.sample) begin
							state_q <= ST_ENTER;
						end else begin
							out_vld_q <= 1'b1;
							out_q     <= meter_t'{cmd.rl, cmd.tl, cmd.cl, 1'b0,
								INDEX_W'(0), HEIGHT_W'(0), HEIGHT_W'(0), 1'b1};
						end
					end
				end
				ST_ENTER: begin
					wpos_q <= wpos_n;
					if (wpos_n == '0) full_q <= 1'b1;
					for (int i = 0; i + 1 < COLUMN_COUNT; i++) begin
						rxcol_q[i] <= rxcol_q[i+1];
						txcol_q[i] <= txcol_q[i+1];
					end
					rxcol_q[COLUMN_COUNT-1] <= cmd_q.rxd;
					txcol_q[COLUMN_COUNT-1] <= cmd_q.txd;
					scan_q  <= '0;
					mx_q    <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (scan_q == WAW'(WINDOW_DEPTH-1)) begin
						state_q <= ST_SCAN_END;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				ST_SCAN_END: begin
					col_q   <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					nrx_q   <= NW'(BAR_STEPS) * NW'(rxcol_q[0]) + NW'(mx_q) - 1'b1;
					ntx_q   <= NW'(BAR_STEPS) * NW'(txcol_q[0]) + NW'(mx_q) - 1'b1;
					small_q <= mx_q < TOTAL_W'(SCALE_MIN);
					qrx_q   <= '0;
					qtx_q   <= '0;
					satrx_q <= 1'b0;
					sattx_q <= 1'b0;
					step_q  <= 3'd4;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					// restoring division, one quotient bit a cycle; bit four saturates
					if (nrx_q >= dv) begin
						nrx_q <= nrx_q - dv;
						if (step_q == 3'd4) satrx_q <= 1'b1;
						else qrx_q[step_q[1:0]] <= 1'b1;
					end
					if (ntx_q >= dv) begin
						ntx_q <= ntx_q - dv;
						if (step_q == 3'd4) sattx_q <= 1'b1;
						else qtx_q[step_q[1:0]] <= 1'b1;
					end
					if (step_q == '0) state_q <= ST_EMIT;
					else step_q <= step_q - 1'b1;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_vld_q             <= 1'b1;
						out_q.rx_light        <= cmd_q.rl;
						out_q.tx_light        <= cmd_q.tl;
						out_q.connected_light <= cmd_q.cl;
						out_q.column_valid    <= 1'b1;
						out_q.column_index    <= INDEX_W'(col_q);
						out_q.rx_height       <= hrx;
						out_q.tx_height       <= htx;
						out_q.last            <= col_q == CW'(COLUMN_COUNT-1);
						// rotate so the next column sits at the head
						for (int i = 0; i + 1 < COLUMN_COUNT; i++) begin
							rxcol_q[i] <= rxcol_q[i+1];
							txcol_q[i] <= txcol_q[i+1];
						end
						rxcol_q[COLUMN_COUNT-1] <= rxcol_q[0];
						txcol_q[COLUMN_COUNT-1] <= txcol_q[0];
						if (col_q == CW'(COLUMN_COUNT-1)) begin
							state_q <= ST_IDLE;
						end else begin
							col_q   <= col_q + 1'b1;
							state_q <= ST_MUL;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`LALM_ASSERT_IMP(a_light_only_last, out_vld_q && !out_q.column_valid, out_q.last, "lights-only result without last")
	`LALM_ASSERT_IMP(a_last_col, out_vld_q && out_q.column_valid && out_q.last, out_q.column_index == INDEX_W'(COLUMN_COUNT-1), "last on wrong column")
	`LALM_ASSERT_NXT(a_enter_scan, state_q == ST_ENTER, state_q == ST_SCAN && scan_q == '0, "enter not followed by scan")
	`LALM_ASSERT_IMP(a_pop_idle, pop, state_q == ST_IDLE && !empty, "pop outside idle")
endmodule

FILE: design/link_activity_load_meter.sv
// Link activity load meter: each tick request yields one lights-only result, and
// every 2*update_rate+1 ticks COLUMN_COUNT bar-column results instead. A sample tick's
// run through the back end is set by the one-entry-a-cycle scan of the peak window
// memory and the five-step height divider run once per column. The front accepts a
// tick per cycle into a two-entry queue, unless the queue is full and stalls ticks.
// Depends on lalm_pkg and the modules lalm_front, lalm_queue and lalm_back.
module link_activity_load_meter import lalm_pkg::*; #(
	parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
	parameter int COLUMN_COUNT = DEF_COLUMN_COUNT,
	parameter int BAR_STEPS    = DEF_BAR_STEPS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              tick_valid,
	output logic              tick_stall,
	input  tick_t             tick_data,
	output logic              meter_valid,
	input  logic              meter_stall,
	output meter_t            meter_data
);
	logic [RATE_W-1:0] rate_q;
	logic              q_full, q_empty, q_pop, accept;
	cmd_t              fcmd, qcmd;

	assign pready     = 1'b1;
	assign prdata     = (paddr[2] == REG_UPDATE_RATE) ? DATA_W'(rate_q) : '0;
	assign tick_stall = q_full;
	assign accept     = tick_valid && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_W'(RATE_RESET);
		end else if (psel && penable && pwrite && paddr[2] == REG_UPDATE_RATE) begin
			rate_q <= pwdata[RATE_W-1:0];
		end
	end

	lalm_front u_front (
		.clk(clk), .arst_n(arst_n), .rate(rate_q), .accept(accept),
		.tick(tick_data), .cmd(fcmd)
	);

	lalm_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(accept), .wdata(fcmd), .pop(q_pop),
		.rdata(qcmd), .full(q_full), .empty(q_empty)
	);

	lalm_back #(
		.WINDOW_DEPTH(WINDOW_DEPTH), .COLUMN_COUNT(COLUMN_COUNT), .BAR_STEPS(BAR_STEPS)
	) u_back (
		.clk(clk), .arst_n(arst_n), .empty(q_empty), .cmd(qcmd), .pop(q_pop),
		.out_valid(meter_valid), .out_stall(meter_stall), .out_data(meter_data)
	);
endmodule

FILE: dv/tb_top.sv
// Testbench for the link activity load meter: random and directed tick requests,
// a scoreboard predicting lights and bar columns, and APB writes of the update rate.
// Depends on lalm_pkg and link_activity_load_meter.
module tb_top;
	import lalm_pkg::*;

	localparam int WIN = DEF_WINDOW_DEPTH;
	localparam int COLS = DEF_COLUMN_COUNT;
	localparam int LIMIT = 3000000;

	class meter_scoreboard;
		bit [TOTAL_W-1:0] peak [WIN];
		int unsigned wpos;
		bit [TOTAL_W-1:0] rx_col [COLS];
		bit [TOTAL_W-1:0] tx_col [COLS];
		int unsigned ticks;
		bit [TOTAL_W-1:0] prev_rx, prev_tx, base_rx, base_tx;
		bit was_up;
		int unsigned rate;
		meter_t pending[$];
		int errors;

		function new();
			foreach (peak[i]) peak[i] = '0;
			foreach (rx_col[i]) begin
				rx_col[i] = '0;
				tx_col[i] = '0;
			end
			wpos = 0; ticks = 0; was_up = 0; rate = RATE_RESET;
			prev_rx = '0; prev_tx = '0; base_rx = '0; base_tx = '0;
			errors = 0;
		endfunction

		function bit [HEIGHT_W-1:0] bar(bit [TOTAL_W-1:0] v, bit [TOTAL_W-1:0] mx);
			longint unsigned h;
			if (mx < SCALE_MIN) h = 64'(v);
			else h = (longint'(DEF_BAR_STEPS) * v + mx - 1) / mx;
			if (h > HEIGHT_MAX) h = 64'(HEIGHT_MAX);
			return h[HEIGHT_W-1:0];
		endfunction

		function void push_sample(bit [TOTAL_W-1:0] rd, bit [TOTAL_W-1:0] td);
			wpos = (wpos + 1 > WIN - 1) ? 0 : wpos + 1;
			peak[wpos] = (td > rd) ? td : rd;
			for (int i = 0; i < COLS - 1; i++) begin
				rx_col[i] = rx_col[i+1];
				tx_col[i] = tx_col[i+1];
			end
			rx_col[COLS-1] = rd;
			tx_col[COLS-1] = td;
		endfunction

		function void note_tick(tick_t t);
			bit rl, tl, cl, smp;
			bit [TOTAL_W-1:0] rx, tx, rd, td, mx;
			meter_t m;
			rl = 0; tl = 0; cl = 0; smp = 0;
			ticks = (ticks + 1) & 6'h3f;
			if (t.link_present) begin
				cl = 1; rx = '0; tx = '0;
				if (t.stats_valid) begin
					rx = t.rx_total; tx = t.tx_total;
					rl = rx > prev_rx; tl = tx > prev_tx;
				end
				if (ticks > 2 * rate) begin
					if (!was_up) begin
						base_rx = rx; base_tx = tx; was_up = 1;
					end
					ticks = 0;
					rd = (rx > base_rx) ? rx - base_rx : '0;
					td = (tx > base_tx) ? tx - base_tx : '0;
					push_sample(rd, td);
					base_rx = rx; base_tx = tx;
					smp = 1;
				end
				prev_rx = rx; prev_tx = tx;
			end else begin
				if (ticks > 2 * rate) begin
					ticks = 0;
					push_sample('0, '0);
					smp = 1;
				end
				was_up = 0;
			end
			m = '0;
			m.rx_light = rl; m.tx_light = tl; m.connected_light = cl;
			if (!smp) begin
				m.last = 1;
				pending.push_back(m);
				return;
			end
			mx = '0;
			foreach (peak[i]) if (peak[i] > mx) mx = peak[i];
			for (int i = 0; i < COLS; i++) begin
				m.column_valid = 1;
				m.column_index = INDEX_W'(i);
				m.rx_height = bar(rx_col[i], mx);
				m.tx_height = bar(tx_col[i], mx);
				m.last = (i == COLS - 1);
				pending.push_back(m);
			end
		endfunction

		function void check_meter(meter_t got);
			meter_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10) $display("mismatch: expected %h actual %h", want, got);
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic tick_valid = 0, tick_stall;
	tick_t tick_data = '0;
	logic meter_valid, meter_stall = 0;
	meter_t meter_data;

	meter_scoreboard sb = new();
	int unsigned cycles = 0;
	int hold_off = 0;
	int rx_wait = 0;
	bit stall_mode = 1;

	link_activity_load_meter dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// receiver: in stall mode a drawn wait after each result, long hold-offs on request
	always @(posedge clk) begin : rx_side
		int w;
		if (arst_n && meter_valid && !meter_stall) sb.check_meter(meter_data);
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			meter_stall <= 1;
		end else if (!stall_mode) begin
			rx_wait <= 0;
			meter_stall <= 0;
		end else if (meter_valid && !meter_stall) begin
			w = $urandom_range(0, 6);
			rx_wait <= w;
			meter_stall <= (w != 0);
		end else if (rx_wait > 1) begin
			rx_wait <= rx_wait - 1;
			meter_stall <= 1;
		end else begin
			rx_wait <= 0;
			meter_stall <= 0;
		end
	end

	task automatic write_rate(int unsigned r);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= {REG_UPDATE_RATE, 2'b00}; pwdata <= r;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		sb.rate = r & 5'h1f;
	endtask

	task automatic send_tick(tick_t t, bit gaps);
		int unsigned g;
		g = gaps ? $urandom_range(0, 6) : 0;
		if (g > 0) begin
			tick_valid <= 0;
			repeat (g) @(posedge clk);
		end
		tick_valid <= 1;
		tick_data <= t;
		@(posedge clk);
		while (tick_stall) @(posedge clk);
		sb.note_tick(t);
	endtask

	task automatic drain();
		tick_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	function automatic tick_t rand_tick(ref bit [TOTAL_W-1:0] rx, ref bit [TOTAL_W-1:0] tx);
		tick_t t;
		int unsigned k;
		k = $urandom_range(0, 99);
		t.link_present = (k > 8);
		t.stats_valid = (k > 4) && (k != 50);
		if (k < 3) begin
			rx = TOTAL_W'($urandom); tx = TOTAL_W'($urandom);
		end else begin
			if ($urandom_range(0, 3) != 0)
				rx = rx + TOTAL_W'($urandom_range(0, 1 << $urandom_range(0, 20)));
			if ($urandom_range(0, 3) != 0)
				tx = tx + TOTAL_W'($urandom_range(0, 1 << $urandom_range(0, 20)));
		end
		t.rx_total = rx; t.tx_total = tx;
		return t;
	endfunction

	initial begin
		tick_t t;
		bit [TOTAL_W-1:0] rx, tx;
		int unsigned rates [6];
		rates = '{0, 31, 1, 2, 20, 3};
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: extremes, link down, stats invalid, backwards totals
		write_rate(0);
		send_tick('{1'b1, 1'b1, 31'd0, 31'd0}, 0);
		send_tick('{1'b1, 1'b1, 31'h7fffffff, 31'd5}, 0);
		send_tick('{1'b1, 1'b1, 31'd3, 31'h7fffffff}, 1);
		send_tick('{1'b1, 1'b0, 31'h7fffffff, 31'h7fffffff}, 0);
		send_tick('{1'b1, 1'b1, 31'd100, 31'd7}, 1);
		send_tick('{1'b0, 1'b1, 31'h7fffffff, 31'd9}, 0);
		send_tick('{1'b0, 1'b0, 31'd0, 31'd0}, 0);
		send_tick('{1'b1, 1'b1, 31'd10, 31'd20}, 0);
		send_tick('{1'b1, 1'b1, 31'd12, 31'd2}, 1);
		send_tick('{1'b1, 1'b1, 31'h55555555, 31'h2aaaaaaa}, 0);
		send_tick('{1'b1, 1'b1, 31'h2aaaaaaa, 31'h55555555}, 0);
		drain();
		write_rate(1);
		for (int i = 0; i < 8; i++) send_tick('{1'b1, 1'b1, 31'(i * 3), 31'(i)}, 1);
		drain();
		rx = '0; tx = '0;
		for (int p = 0; p < 6; p++) begin
			write_rate(rates[p]);
			stall_mode = (p != 2);
			if (p == 1) hold_off = 2000;
			for (int i = 0; i < 35; i++) begin
				t = rand_tick(rx, tx);
				send_tick(t, (p != 3) && (i % 10 < 7));
			end
			// pause until everything is back
			drain();
		end
		if (sb.errors == 0 && sb.pending.size() == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end
endmodule

FILE: sim.f
+incdir+design
design/lalm_pkg.sv
design/lalm_front.sv
design/lalm_queue.sv
design/lalm_back.sv
design/link_activity_load_meter.sv
dv/tb_top.sv
